/* rtl/mic_pkg.sv */
// mic_pkg: constants and small tables for the 4x4 adjugate matrix inverse
// no dependencies; used by matrix_inverse_cofactor_unit

package mic_pkg;

    localparam int MAT_N     = 4;
    localparam int ELEM_CNT  = MAT_N * MAT_N;
    localparam int IDX_W     = $clog2(ELEM_CNT);
    localparam int POS_W     = $clog2(MAT_N);
    localparam int EW        = 24;               // element width, signed
    localparam int X_W       = 3 * EW;           // cofactor magnitude
    localparam int P_W       = 4 * EW;           // widest product
    localparam int COF_W     = 3 * EW + 2;       // signed cofactor
    localparam int DET_W     = 4 * EW + 4;       // signed determinant
    localparam int FRAC_BITS = EW / 2;
    localparam int Q_SHIFT   = FRAC_BITS + 16;   // scale of the quotient
    localparam int OUT_W     = 32;
    localparam int Q_W       = OUT_W + 1;        // quotient bits kept
    localparam int OVF_SH    = Q_W - Q_SHIFT;    // quotient >= 2^Q_W test shift
    localparam int QI_W      = $clog2(Q_W + 1);
    localparam int PERM_CNT  = 6;

    // permutation of three columns: entry t, factor f
    function automatic logic [1:0] perm_idx(input logic [2:0] t, input logic [1:0] f);
        logic [5:0] p;
        unique case (t)
            3'd0:    p = {2'd2, 2'd1, 2'd0};
            3'd1:    p = {2'd1, 2'd2, 2'd0};
            3'd2:    p = {2'd2, 2'd0, 2'd1};
            3'd3:    p = {2'd0, 2'd2, 2'd1};
            3'd4:    p = {2'd1, 2'd0, 2'd2};
            3'd5:    p = {2'd0, 2'd1, 2'd2};
            default: p = {2'd2, 2'd1, 2'd0};
        endcase
        return p[f*2 +: 2];
    endfunction

    // odd permutations subtract their term
    function automatic logic perm_odd(input logic [2:0] t);
        return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
    endfunction

endpackage

/* rtl/matrix_inverse_cofactor_unit.sv */
// 4x4 matrix inverse by adjugate over determinant, shared multiplier and divider (mic_pkg)
// after the 16th load each cofactor sums 6 terms (three factors, the third in two chunks, then
// accumulate) and is stored; the determinant sums 4 row-0 products; each result then loads its
// dividend, divides and is emitted; a zero determinant or a quotient out of range skips the
// divide for that result; no new matrix is taken while busy; results strobed one cycle each,
// no back pressure; sync active-low reset clears sequencer, load count and output strobe only

module matrix_inverse_cofactor_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [mic_pkg::EW-1:0] i_element_value,
    output logic                          o_strobe,
    output logic signed [mic_pkg::OUT_W-1:0] o_inverse_value,
    output logic                          o_singular,
    output logic                          o_saturated,
    output logic                          o_last_element
);

    // sequencer states
    localparam logic [3:0] S_LOAD = 4'd0;   // idle, taking elements
    localparam logic [3:0] S_F1   = 4'd1;   // first factor of a term
    localparam logic [3:0] S_F2   = 4'd2;   // times second factor
    localparam logic [3:0] S_F3   = 4'd3;   // times third factor, two chunks
    localparam logic [3:0] S_ACC  = 4'd4;   // add term into the cofactor sum
    localparam logic [3:0] S_CST  = 4'd5;   // store the signed cofactor
    localparam logic [3:0] S_DX   = 4'd6;   // fetch row-0 cofactor
    localparam logic [3:0] S_DM   = 4'd7;   // times row-0 element, three chunks
    localparam logic [3:0] S_DACC = 4'd8;   // add into determinant
    localparam logic [3:0] S_DSET = 4'd9;   // latch determinant magnitude and sign
    localparam logic [3:0] S_QLD  = 4'd10;  // load dividend, overflow check
    localparam logic [3:0] S_QDIV = 4'd11;  // one quotient bit per cycle
    localparam logic [3:0] S_QOUT = 4'd12;  // saturate and emit

    logic [3:0]                         r_state, n_state;
    logic [mic_pkg::IDX_W-1:0]          r_cnt, n_cnt;
    logic [mic_pkg::IDX_W-1:0]          r_k, n_k;
    logic [2:0]                         r_t, n_t;
    logic [1:0]                         r_j, n_j;
    logic [mic_pkg::QI_W-1:0]           r_i, n_i;
    logic [mic_pkg::X_W-1:0]            r_x, n_x;
    logic [mic_pkg::P_W-1:0]            r_p, n_p;
    logic                               r_neg, n_neg;
    logic signed [mic_pkg::DET_W-1:0]   r_acc, n_acc;
    logic [mic_pkg::DET_W-1:0]          r_dmag, n_dmag;
    logic                               r_dneg, n_dneg;
    logic                               r_sing, n_sing;
    logic [mic_pkg::DET_W-1:0]          r_rem, n_rem;
    logic [mic_pkg::Q_W-1:0]            r_q, n_q;
    logic                               r_ovf, n_ovf;
    logic                               r_qneg, n_qneg;

    logic                               r_o_valid, n_o_valid;
    logic signed [mic_pkg::OUT_W-1:0]   r_o_value, n_o_value;
    logic                               r_o_sing, n_o_sing;
    logic                               r_o_sat, n_o_sat;
    logic                               r_o_last, n_o_last;

    // element store and cofactor store
    logic [mic_pkg::EW-1:0]             r_mat [mic_pkg::ELEM_CNT];
    logic signed [mic_pkg::COF_W-1:0]   r_cof [mic_pkg::ELEM_CNT];

    logic                               accept;
    logic [1:0]                         f_sel, pc, col, row, oc, orow;
    logic [mic_pkg::IDX_W-1:0]          el_addr;
    logic [mic_pkg::EW-1:0]             el_rd, el_mag;
    logic                               el_neg;
    logic signed [mic_pkg::COF_W-1:0]   cof_rd, cof_wr;
    logic [mic_pkg::COF_W-1:0]          cof_mag;
    logic [mic_pkg::EW-1:0]             mul_a;
    logic [2*mic_pkg::EW-1:0]           mul_y;
    logic [mic_pkg::P_W-1:0]            pp_sh;
    logic signed [mic_pkg::DET_W-1:0]   term;
    logic [mic_pkg::DET_W:0]            div_sh;
    logic                               div_ge;
    logic                               div_bit;
    logic [mic_pkg::QI_W-1:0]           bit_pos;
    logic [mic_pkg::DET_W+mic_pkg::OVF_SH-1:0] ovf_lhs, ovf_rhs;
    logic                               sat_pos, sat_neg;

    assign accept = start && !busy;
    assign busy   = (r_state != S_LOAD);

    // output position of the cofactor under work: column oc, row orow
    assign oc   = r_k[3:2];
    assign orow = r_k[1:0];

    // element address: the minor drops column orow and row oc
    always_comb begin
        unique case (r_state)
            S_F1:    f_sel = 2'd0;
            S_F2:    f_sel = 2'd1;
            default: f_sel = 2'd2;
        endcase
        pc  = mic_pkg::perm_idx(r_t, f_sel);
        col = (pc < orow) ? pc : pc + 2'd1;
        row = (f_sel < oc) ? f_sel : f_sel + 2'd1;
        if (r_state == S_DM) begin
            el_addr = {orow, 2'd0};
        end else begin
            el_addr = {col, row};
        end
    end

    assign el_rd  = r_mat[el_addr];
    assign el_neg = el_rd[mic_pkg::EW-1];
    assign el_mag = el_neg ? (~el_rd + 1'b1) : el_rd;

    assign cof_rd  = r_cof[r_k];
    assign cof_mag = cof_rd[mic_pkg::COF_W-1] ? (~cof_rd + 1'b1) : cof_rd;

    // shared 24x24 multiplier on one chunk of the running multiplicand
    assign mul_a = r_x[r_j*mic_pkg::EW +: mic_pkg::EW];
    assign mul_y = mul_a * el_mag;
    assign pp_sh = mic_pkg::P_W'(mul_y) << (r_j * mic_pkg::EW);

    assign term = (r_neg ^ ((r_state == S_ACC) && mic_pkg::perm_odd(r_t)))
                ? -$signed(mic_pkg::DET_W'(r_p)) : $signed(mic_pkg::DET_W'(r_p));

    // signed cofactor with checkerboard sign
    assign cof_wr = (oc[0] ^ orow[0]) ? mic_pkg::COF_W'(-r_acc) : mic_pkg::COF_W'(r_acc);

    // quotient overflow when dividend >= divisor * 2^Q_W
    assign ovf_lhs = (mic_pkg::DET_W + mic_pkg::OVF_SH)'(cof_mag);
    assign ovf_rhs = {r_dmag, {mic_pkg::OVF_SH{1'b0}}};

    // restoring divide step; dividend low bits are the low magnitude bits then zeros
    assign bit_pos = r_i - mic_pkg::QI_W'(mic_pkg::Q_SHIFT);
    assign div_bit = (r_i >= mic_pkg::QI_W'(mic_pkg::Q_SHIFT)) ? r_x[bit_pos[2:0]] : 1'b0;
    assign div_sh  = {r_rem, div_bit};
    assign div_ge  = (div_sh >= {1'b0, r_dmag});

    assign sat_pos = r_ovf || (r_q[mic_pkg::Q_W-1:mic_pkg::OUT_W-1] != 2'b00);
    assign sat_neg = r_ovf || (r_q > {2'b01, {(mic_pkg::OUT_W-1){1'b0}}});

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_k       = r_k;
        n_t       = r_t;
        n_j       = r_j;
        n_i       = r_i;
        n_x       = r_x;
        n_p       = r_p;
        n_neg     = r_neg;
        n_acc     = r_acc;
        n_dmag    = r_dmag;
        n_dneg    = r_dneg;
        n_sing    = r_sing;
        n_rem     = r_rem;
        n_q       = r_q;
        n_ovf     = r_ovf;
        n_qneg    = r_qneg;
        n_o_valid = 1'b0;
        n_o_value = r_o_value;
        n_o_sing  = r_o_sing;
        n_o_sat   = r_o_sat;
        n_o_last  = r_o_last;
        unique case (r_state)
            S_LOAD: begin
                if (accept) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == mic_pkg::IDX_W'(mic_pkg::ELEM_CNT - 1)) begin
                        n_state = S_F1;
                        n_k     = '0;
                        n_t     = '0;
                        n_acc   = '0;
                    end
                end
            end
            S_F1: begin
                n_x     = mic_pkg::X_W'(el_mag);
                n_neg   = el_neg;
                n_j     = '0;
                n_state = S_F2;
            end
            S_F2: begin
                n_x     = mic_pkg::X_W'(mul_y);
                n_neg   = r_neg ^ el_neg;
                n_p     = '0;
                n_j     = '0;
                n_state = S_F3;
            end
            S_F3: begin
                n_p = r_p + pp_sh;
                n_j = r_j + 2'd1;
                if (r_j == 2'd0) begin
                    n_neg = r_neg ^ el_neg;
                end else begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_acc = r_acc + term;
                n_t   = r_t + 3'd1;
                if (r_t == 3'(mic_pkg::PERM_CNT - 1)) begin
                    n_state = S_CST;
                end else begin
                    n_state = S_F1;
                end
            end
            S_CST: begin
                n_acc = '0;
                n_t   = '0;
                n_k   = r_k + 1'b1;
                if (r_k == mic_pkg::IDX_W'(mic_pkg::ELEM_CNT - 1)) begin
                    n_state = S_DX;
                end else begin
                    n_state = S_F1;
                end
            end
            S_DX: begin
                n_x     = mic_pkg::X_W'(cof_mag);
                n_neg   = cof_rd[mic_pkg::COF_W-1];
                n_p     = '0;
                n_j     = '0;
                n_state = S_DM;
            end
            S_DM: begin
                n_p = r_p + pp_sh;
                n_j = r_j + 2'd1;
                if (r_j == 2'd0) begin
                    n_neg = r_neg ^ el_neg;
                end
                if (r_j == 2'd2) begin
                    n_state = S_DACC;
                end
            end
            S_DACC: begin
                n_acc = r_acc + term;
                n_k   = r_k + 1'b1;
                if (r_k == mic_pkg::IDX_W'(mic_pkg::MAT_N - 1)) begin
                    n_state = S_DSET;
                end else begin
                    n_state = S_DX;
                end
            end
            S_DSET: begin
                n_sing  = (r_acc == '0);
                n_dneg  = r_acc[mic_pkg::DET_W-1];
                n_dmag  = r_acc[mic_pkg::DET_W-1] ? mic_pkg::DET_W'(-r_acc)
                                                  : mic_pkg::DET_W'(r_acc);
                n_k     = '0;
                n_state = S_QLD;
            end
            S_QLD: begin
                n_x     = mic_pkg::X_W'(cof_mag);
                n_qneg  = cof_rd[mic_pkg::COF_W-1] ^ r_dneg;
                n_ovf   = (ovf_lhs >= ovf_rhs);
                n_rem   = mic_pkg::DET_W'(cof_mag >> mic_pkg::OVF_SH);
                n_q     = '0;
                n_i     = mic_pkg::QI_W'(mic_pkg::Q_W - 1);
                if (r_sing || (ovf_lhs >= ovf_rhs)) begin
                    n_state = S_QOUT;
                end else begin
                    n_state = S_QDIV;
                end
            end
            S_QDIV: begin
                n_q = {r_q[mic_pkg::Q_W-2:0], div_ge};
                if (div_ge) begin
                    n_rem = mic_pkg::DET_W'(div_sh - {1'b0, r_dmag});
                end else begin
                    n_rem = mic_pkg::DET_W'(div_sh);
                end
                n_i = r_i - 1'b1;
                if (r_i == '0) begin
                    n_state = S_QOUT;
                end
            end
            S_QOUT: begin
                n_o_valid = 1'b1;
                n_o_sing  = r_sing;
                n_o_last  = (r_k == mic_pkg::IDX_W'(mic_pkg::ELEM_CNT - 1));
                if (r_sing) begin
                    n_o_value = '0;
                    n_o_sat   = 1'b0;
                end else if (!r_qneg) begin
                    n_o_sat   = sat_pos;
                    n_o_value = sat_pos ? {1'b0, {(mic_pkg::OUT_W-1){1'b1}}}
                                        : $signed(r_q[mic_pkg::OUT_W-1:0]);
                end else begin
                    n_o_sat   = sat_neg;
                    n_o_value = sat_neg ? {1'b1, {(mic_pkg::OUT_W-1){1'b0}}}
                                        : -$signed(r_q[mic_pkg::OUT_W-1:0]);
                end
                n_k = r_k + 1'b1;
                if (r_k == mic_pkg::IDX_W'(mic_pkg::ELEM_CNT - 1)) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_QLD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_t       <= n_t;
        r_j       <= n_j;
        r_i       <= n_i;
        r_x       <= n_x;
        r_p       <= n_p;
        r_neg     <= n_neg;
        r_acc     <= n_acc;
        r_dmag    <= n_dmag;
        r_dneg    <= n_dneg;
        r_sing    <= n_sing;
        r_rem     <= n_rem;
        r_q       <= n_q;
        r_ovf     <= n_ovf;
        r_qneg    <= n_qneg;
        r_o_value <= n_o_value;
        r_o_sing  <= n_o_sing;
        r_o_sat   <= n_o_sat;
        r_o_last  <= n_o_last;
    end

    // element store written on each accepted item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mat[r_cnt] <= i_element_value;
        end
    end

    // cofactor store
    always_ff @(posedge i_clk) begin
        if (r_state == S_CST) begin
            r_cof[r_k] <= cof_wr;
        end
    end

    assign o_strobe        = r_o_valid;
    assign o_inverse_value = r_o_value;
    assign o_singular      = r_o_sing;
    assign o_saturated     = r_o_sat;
    assign o_last_element  = r_o_last;

endmodule
